/* rtl/core/lgge_pkg.sv */
// Shared constants for the life grid generation engine: action codes,
// configuration register indexes, rule counts and default sizes.
// No dependencies.
package lgge_pkg;

  localparam int DEFAULT_MAX_WIDTH  = 64;
  localparam int DEFAULT_MAX_HEIGHT = 64;

  localparam int GRID_REG_W = 7;
  localparam logic [GRID_REG_W-1:0] GRID_REG_RESET = 7'd64;

  localparam logic [1:0] ACT_WRITE   = 2'd0;
  localparam logic [1:0] ACT_READ    = 2'd1;
  localparam logic [1:0] ACT_ADVANCE = 2'd2;

  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;

  localparam logic [3:0] BIRTH_COUNT  = 4'd3;
  localparam logic [3:0] SURVIVE_LOW  = 4'd2;
  localparam logic [3:0] SURVIVE_HIGH = 4'd3;

endpackage

/* rtl/core/lgge_bank.sv */
// One row bank of the grid: a row-wide memory with one write and one
// registered read port, plus a per-row valid bit so that reset reads as dead.
// No package dependencies.
module lgge_bank #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] row_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // A row that has not been written since reset reads as all dead.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (wr_en) begin
      row_valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= row_valid[rd_addr] ? mem[rd_addr] : '0;
    end
  end

endmodule

/* rtl/core/lgge_row_unit.sv */
// Rule unit: works out the next generation of one whole row from the row
// above, the row itself and the row below. Depends on lgge_pkg.
module lgge_row_unit #(
  parameter int WIDTH = 64
) (
  input  logic [WIDTH-1:0]                  above,
  input  logic [WIDTH-1:0]                  middle,
  input  logic [WIDTH-1:0]                  below,
  input  logic [lgge_pkg::GRID_REG_W-1:0]   width,
  input  logic                              row_live,
  output logic [WIDTH-1:0]                  next_row
);

  logic [WIDTH-1:0] col_mask;
  logic [WIDTH+1:0] pad_a;
  logic [WIDTH+1:0] pad_m;
  logic [WIDTH+1:0] pad_b;
  logic [3:0]       count [WIDTH];

  // Columns at or beyond the configured width count as dead on both sides.
  always_comb begin
    for (int i = 0; i < WIDTH; i++) begin
      col_mask[i] = (lgge_pkg::GRID_REG_W'(i) < width);
    end
  end

  assign pad_a = {1'b0, above & col_mask, 1'b0};
  assign pad_m = {1'b0, middle & col_mask, 1'b0};
  assign pad_b = {1'b0, below & col_mask, 1'b0};

  always_comb begin
    for (int i = 0; i < WIDTH; i++) begin
      count[i] = 4'(pad_a[i]) + 4'(pad_a[i+1]) + 4'(pad_a[i+2])
               + 4'(pad_m[i]) + 4'(pad_m[i+2])
               + 4'(pad_b[i]) + 4'(pad_b[i+1]) + 4'(pad_b[i+2]);
      if (pad_m[i+1]) begin
        next_row[i] = row_live && col_mask[i]
                      && (count[i] >= lgge_pkg::SURVIVE_LOW)
                      && (count[i] <= lgge_pkg::SURVIVE_HIGH);
      end else begin
        next_row[i] = row_live && col_mask[i] && (count[i] == lgge_pkg::BIRTH_COUNT);
      end
    end
  end

endmodule

/* rtl/core/life_grid_generation_engine.sv */
// Life grid generation engine: a double-buffered grid that advances by the
// B3/S23 rule, with single-cell read and write items.
// Depends on lgge_pkg, lgge_bank and lgge_row_unit.
// A cell read or write passes through the look and resolve states before its
// result; an out-of-range or unused item goes straight to the done state.
// Throughput: one item at a time; the next is taken as the result appears.
// During an advance the rule unit handles one row per cycle, fed by the
// single read port of the source bank.
// Reset: synchronous; clears control, the row valid bits of both banks and
// sets both size registers to 64. No clearing pass is needed.
module life_grid_generation_engine #(
  parameter int MAX_WIDTH  = lgge_pkg::DEFAULT_MAX_WIDTH,
  parameter int MAX_HEIGHT = lgge_pkg::DEFAULT_MAX_HEIGHT
) (
  input  logic        clk,
  input  logic        rst,
  // Input items.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // cell_x[5:0], cell_y[11:6], cell_value[12], zero fill
  input  logic [1:0]  s_tuser,   // action[1:0]
  // Result items.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // read_alive[0], address_error[1], zero fill
  // Configuration writes.
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data
);

  localparam int GW   = lgge_pkg::GRID_REG_W;
  localparam int AW   = $clog2(MAX_HEIGHT);
  localparam int XW   = $clog2(MAX_WIDTH);
  localparam int CW   = $clog2(MAX_HEIGHT + 2);
  localparam int CMPW = (CW > GW) ? CW : GW;

  // Sequencer states.
  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_LOOK    = 3'd1;
  localparam logic [2:0] ST_RESOLVE = 3'd2;
  localparam logic [2:0] ST_ADV     = 3'd3;
  localparam logic [2:0] ST_DONE    = 3'd4;

  logic [2:0]          state;
  logic                cur_bank;
  logic [GW-1:0]       grid_width;
  logic [GW-1:0]       grid_height;

  logic [1:0]          act_q;
  logic [5:0]          x_q;
  logic [5:0]          y_q;
  logic                val_q;
  logic                res_alive;
  logic                res_err;
  logic [CW-1:0]       step;
  logic [MAX_WIDTH-1:0] prev_row;
  logic [MAX_WIDTH-1:0] mid_row;

  // Unpacked input fields.
  logic [1:0]          in_action;
  logic [5:0]          in_x;
  logic [5:0]          in_y;
  logic                in_value;
  logic                in_inside;

  logic [GW-1:0]       eff_w;
  logic [CMPW-1:0]     eff_h;
  logic [CMPW-1:0]     step_ext;

  logic                rd_req;
  logic [AW-1:0]       rd_addr;
  logic [MAX_WIDTH-1:0] rd_a;
  logic [MAX_WIDTH-1:0] rd_b;
  logic [MAX_WIDTH-1:0] rdata;
  logic [MAX_WIDTH-1:0] below_row;
  logic [MAX_WIDTH-1:0] cell_row;
  logic [MAX_WIDTH-1:0] gen_row;
  logic [MAX_WIDTH-1:0] wr_data;
  logic [AW-1:0]       wr_addr;
  logic                wr_cell;
  logic                wr_adv;
  logic                below_live;
  logic                out_live;
  logic                out_free;

  assign in_action = s_tuser;
  assign in_x      = s_tdata[5:0];
  assign in_y      = s_tdata[11:6];
  assign in_value  = s_tdata[12];

  // Sizes above the build limits are clamped to them.
  assign eff_w = (grid_width > GW'(MAX_WIDTH)) ? GW'(MAX_WIDTH) : grid_width;
  assign eff_h = (CMPW'(grid_height) > CMPW'(MAX_HEIGHT)) ? CMPW'(MAX_HEIGHT)
                                                          : CMPW'(grid_height);

  assign in_inside = (GW'(in_x) < eff_w) && (CMPW'(in_y) < eff_h);

  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign step_ext = CMPW'(step);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= lgge_pkg::GRID_REG_RESET;
      grid_height <= lgge_pkg::GRID_REG_RESET;
    end else if (cfg_we) begin
      if (cfg_index == lgge_pkg::REG_GRID_WIDTH) begin
        grid_width <= cfg_data;
      end else begin
        grid_height <= cfg_data;
      end
    end
  end

  // Read port of the current bank. During an advance the rows are read in
  // order, one per cycle; the data of row step-1 arrives while step is current.
  assign rd_req  = (state == ST_LOOK) || ((state == ST_ADV) && (step < CW'(MAX_HEIGHT)));
  assign rd_addr = (state == ST_LOOK) ? AW'(y_q) : AW'(step);
  assign rdata   = cur_bank ? rd_b : rd_a;

  // The row arriving from the bank is the lower neighbour of the row being
  // produced; rows at or beyond the configured height count as dead.
  assign below_live = (step != '0) && ((step_ext - CMPW'(1)) < eff_h);
  assign below_row  = below_live ? rdata : '0;
  assign out_live   = (step_ext - CMPW'(2)) < eff_h;

  lgge_row_unit #(
    .WIDTH (MAX_WIDTH)
  ) u_row_unit (
    .above    (prev_row),
    .middle   (mid_row),
    .below    (below_row),
    .width    (eff_w),
    .row_live (out_live),
    .next_row (gen_row)
  );

  // A cell write is a read-modify-write of its row in the current bank.
  always_comb begin
    cell_row = rdata;
    cell_row[XW'(x_q)] = val_q;
  end

  assign wr_cell = (state == ST_RESOLVE) && (act_q == lgge_pkg::ACT_WRITE);
  assign wr_adv  = (state == ST_ADV) && (step >= CW'(2));
  assign wr_data = wr_cell ? cell_row : gen_row;
  assign wr_addr = wr_cell ? AW'(y_q) : AW'(step - CW'(2));

  // Cell items touch the current bank; an advance writes the other one.
  lgge_bank #(
    .WIDTH (MAX_WIDTH),
    .DEPTH (MAX_HEIGHT)
  ) u_bank_a (
    .clk     (clk),
    .rst     (rst),
    .wr_en   ((wr_cell && !cur_bank) || (wr_adv && cur_bank)),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_req && !cur_bank),
    .rd_addr (rd_addr),
    .rd_data (rd_a)
  );

  lgge_bank #(
    .WIDTH (MAX_WIDTH),
    .DEPTH (MAX_HEIGHT)
  ) u_bank_b (
    .clk     (clk),
    .rst     (rst),
    .wr_en   ((wr_cell && cur_bank) || (wr_adv && !cur_bank)),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_req && cur_bank),
    .rd_addr (rd_addr),
    .rd_data (rd_b)
  );

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cur_bank <= 1'b0;
      step     <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            step <= '0;
            if (in_action == lgge_pkg::ACT_ADVANCE) begin
              state <= ST_ADV;
            end else if ((in_action == lgge_pkg::ACT_WRITE ||
                          in_action == lgge_pkg::ACT_READ) && in_inside) begin
              state <= ST_LOOK;
            end else begin
              state <= ST_DONE;
            end
          end
        end
        ST_LOOK: begin
          state <= ST_RESOLVE;
        end
        ST_RESOLVE: begin
          state <= ST_DONE;
        end
        ST_ADV: begin
          if (step == CW'(MAX_HEIGHT + 1)) begin
            cur_bank <= !cur_bank;
            state    <= ST_DONE;
          end else begin
            step <= step + CW'(1);
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Item fields, the row window of an advance and the pending result.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      act_q     <= in_action;
      x_q       <= in_x;
      y_q       <= in_y;
      val_q     <= in_value;
      res_alive <= 1'b0;
      res_err   <= (in_action == lgge_pkg::ACT_WRITE || in_action == lgge_pkg::ACT_READ)
                   && !in_inside;
      prev_row  <= '0;
      mid_row   <= '0;
    end else begin
      if ((state == ST_RESOLVE) && (act_q == lgge_pkg::ACT_READ)) begin
        res_alive <= rdata[XW'(x_q)];
      end
      if ((state == ST_ADV) && (step != '0)) begin
        prev_row <= mid_row;
        mid_row  <= below_row;
      end
    end
  end

  // Output register: it holds one finished result until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == ST_DONE) && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && out_free) begin
      m_tdata <= {6'd0, res_err, res_alive};
    end
  end

endmodule

/* rtl/core/lgge_checker.sv */
// Port-level checks for the life grid generation engine, attached by bind.
// Depends on lgge_pkg and the top-level module life_grid_generation_engine.
module lgge_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [15:0] s_tdata,
  input logic [1:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [7:0]  m_tdata
);

  // A stalled result holds its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result item changed while stalled");

  // The block works on one item at a time.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("item accepted while the previous one is in progress");

  // An advance walks every row, so it keeps the input closed while it does so.
  a_adv_long: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == lgge_pkg::ACT_ADVANCE)
    |=> !s_tready ##1 !s_tready ##1 !s_tready ##1 !s_tready)
    else $error("advance finished too early");

  // Reset leaves the block empty and ready.
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("block not idle after reset");

endmodule

bind life_grid_generation_engine lgge_checker u_lgge_checker (.*);

/* tb/sv/testbench.sv */
// Self-checking testbench for life_grid_generation_engine: cell writes, reads and
// generation steps, predicted by an in-bench B3/S23 grid.
// Depends on lgge_pkg and the engine RTL only.
module testbench;

  // Grid size of the instance; the predictor keeps its banks at the same size.
  localparam int GRID_COLS = lgge_pkg::DEFAULT_MAX_WIDTH;
  localparam int GRID_ROWS = lgge_pkg::DEFAULT_MAX_HEIGHT;

  // Action code 3 is not used by the block; it must give an all-zero result.
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  // The run is stopped here whatever happens. The slowest correct run is every
  // item an advance plus the longest gaps and stalls, which stays well under a
  // quarter of this.
  localparam int CYCLE_LIMIT = 1_000_000;

  // Ready pattern for the receiver's patterned stall mode, one bit per cycle.
  localparam logic [15:0] READY_PATTERN = 16'b1100_0001_1101_0111;

  localparam int RANDOM_PHASES   = 12;
  localparam int ITEMS_PER_PHASE = 170;

  typedef struct packed {
    logic [1:0] action;
    logic [5:0] cell_x;
    logic [5:0] cell_y;
    logic       cell_value;
  } life_item_t;

  typedef struct packed {
    logic read_alive;
    logic address_error;
  } cell_result_t;

  typedef enum logic {ROW_ITEM, ROW_CONFIG} row_kind_t;

  // One row of the directed plan. A row either sends an item or writes a
  // register; where fixed is set the expected result is the one typed in the
  // row rather than the one the predictor works out.
  typedef struct packed {
    row_kind_t    kind;
    life_item_t   item;
    logic         cfg_reg;
    logic [6:0]   cfg_value;
    logic         fixed;
    cell_result_t fixed_result;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;   // cell_x[5:0], cell_y[11:6], cell_value[12], zero fill
  logic [1:0]  s_tuser = '0;   // action[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;        // read_alive[0], address_error[1], zero fill
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [6:0]  cfg_data = '0;

  life_grid_generation_engine i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Grid predictor. Both banks live in one array: bank b, row y sits at entry
  // b * GRID_ROWS + y, and bit x of an entry is cell (x, y).
  // ---------------------------------------------------------------------------
  logic [GRID_COLS-1:0] bank_rows [2*GRID_ROWS];
  logic                 cur_bank;
  logic [6:0]           width_reg;
  logic [6:0]           height_reg;

  cell_result_t pending_cell_results [$];

  int mismatch_count = 0;
  int cycle_count    = 0;
  int items_sent     = 0;
  int writes_sent    = 0;
  int reads_sent     = 0;
  int advances_sent  = 0;
  int results_seen   = 0;
  int size_settings  = 0;
  int burst_left     = 0;

  // A register above the instance size is clipped to it.
  function automatic int used_cols();
    return (int'(width_reg) > GRID_COLS) ? GRID_COLS : int'(width_reg);
  endfunction

  function automatic int used_rows();
    return (int'(height_reg) > GRID_ROWS) ? GRID_ROWS : int'(height_reg);
  endfunction

  // Anything outside the configured area counts as dead; there is no wrap.
  function automatic logic cell_alive_at(int x, int y);
    if (x < 0 || y < 0 || x >= used_cols() || y >= used_rows()) return 1'b0;
    return bank_rows[int'(cur_bank) * GRID_ROWS + y][x];
  endfunction

  // One generation: read the current bank only, fill the other one, and swap.
  // Cells outside the configured area come out dead.
  function automatic void advance_generation();
    logic [GRID_COLS-1:0] next_row;
    int                   neighbours;
    int                   dest_base;
    dest_base = cur_bank ? 0 : GRID_ROWS;
    for (int y = 0; y < GRID_ROWS; y++) begin
      next_row = '0;
      for (int x = 0; x < GRID_COLS; x++) begin
        if (x < used_cols() && y < used_rows()) begin
          neighbours = 0;
          for (int dy = -1; dy <= 1; dy++) begin
            for (int dx = -1; dx <= 1; dx++) begin
              if (dx != 0 || dy != 0) neighbours += int'(cell_alive_at(x + dx, y + dy));
            end
          end
          if (cell_alive_at(x, y)) begin
            next_row[x] = (neighbours >= int'(lgge_pkg::SURVIVE_LOW)) &&
                          (neighbours <= int'(lgge_pkg::SURVIVE_HIGH));
          end else begin
            next_row[x] = (neighbours == int'(lgge_pkg::BIRTH_COUNT));
          end
        end
      end
      bank_rows[dest_base + y] = next_row;
    end
    cur_bank = ~cur_bank;
  endfunction

  // Applies one accepted item to the predicted grid and gives its result.
  function automatic cell_result_t apply_life_item(life_item_t it);
    cell_result_t res;
    logic         in_grid;
    int           row_index;
    res       = '0;
    in_grid   = (int'(it.cell_x) < used_cols()) && (int'(it.cell_y) < used_rows());
    row_index = int'(cur_bank) * GRID_ROWS + int'(it.cell_y);
    case (it.action)
      lgge_pkg::ACT_WRITE, lgge_pkg::ACT_READ: begin
        if (!in_grid) begin
          res.address_error = 1'b1;
        end else if (it.action == lgge_pkg::ACT_WRITE) begin
          bank_rows[row_index][it.cell_x] = it.cell_value;
        end else begin
          res.read_alive = bank_rows[row_index][it.cell_x];
        end
      end
      lgge_pkg::ACT_ADVANCE: begin
        advance_generation();
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  function automatic life_item_t make_item(logic [1:0] action, int x, int y, logic v);
    life_item_t it;
    it.action     = action;
    it.cell_x     = x[5:0];
    it.cell_y     = y[5:0];
    it.cell_value = v;
    return it;
  endfunction

  function automatic plan_row_t item_row(logic [1:0] action, int x, int y, logic v);
    plan_row_t row;
    row      = '0;
    row.kind = ROW_ITEM;
    row.item = make_item(action, x, y, v);
    return row;
  endfunction

  function automatic plan_row_t fixed_row(logic [1:0] action, int x, int y, logic v,
                                          logic alive, logic err);
    plan_row_t row;
    row = item_row(action, x, y, v);
    row.fixed                      = 1'b1;
    row.fixed_result.read_alive    = alive;
    row.fixed_result.address_error = err;
    return row;
  endfunction

  function automatic plan_row_t config_row(logic reg_index, int value);
    plan_row_t row;
    row           = '0;
    row.kind      = ROW_CONFIG;
    row.cfg_reg   = reg_index;
    row.cfg_value = value[6:0];
    return row;
  endfunction

  // A coordinate in 0..n-1 that lands on either border half of the time.
  function automatic int pick_coord(int n);
    int roll;
    roll = $urandom_range(0, 3);
    if (roll == 0) return 0;
    if (roll == 1) return n - 1;
    return $urandom_range(0, n - 1);
  endfunction

  // Random item for a grid of cols x rows. Most reads and writes fall in a
  // small window so that patterns form and evolve; about one in ten goes
  // outside the grid where the grid leaves room for it.
  function automatic life_item_t random_item(int cols, int rows, int win_x, int win_y,
                                             int win_w, int win_h);
    life_item_t it;
    int         roll;
    it   = make_item(lgge_pkg::ACT_READ, $urandom_range(0, 63), $urandom_range(0, 63),
                     1'($urandom_range(0, 1)));
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      it.action = ACT_UNUSED;
    end else if (roll < 13) begin
      it.action = lgge_pkg::ACT_ADVANCE;
    end else begin
      it.action     = (roll < 58) ? lgge_pkg::ACT_WRITE : lgge_pkg::ACT_READ;
      it.cell_value = ($urandom_range(0, 99) < 60);
      if (cols == 0 || rows == 0 ||
          ((cols < GRID_COLS || rows < GRID_ROWS) && $urandom_range(0, 9) == 0)) begin
        if (cols < GRID_COLS && (rows == GRID_ROWS || $urandom_range(0, 1) == 1)) begin
          it.cell_x = 6'($urandom_range(cols, GRID_COLS - 1));
        end else if (rows < GRID_ROWS) begin
          it.cell_y = 6'($urandom_range(rows, GRID_ROWS - 1));
        end
      end else if ($urandom_range(0, 4) != 0) begin
        it.cell_x = 6'(win_x + $urandom_range(0, win_w - 1));
        it.cell_y = 6'(win_y + $urandom_range(0, win_h - 1));
      end else begin
        it.cell_x = 6'(pick_coord(cols));
        it.cell_y = 6'(pick_coord(rows));
      end
    end
    return it;
  endfunction

  // Sends one item. The sender works in bursts: at the start of each burst
  // it may drop tvalid for a random gap, and inside a burst tvalid stays high
  // from one item to the next. The prediction is taken at the accepting edge.
  task automatic send_item(life_item_t it, logic fixed, cell_result_t fixed_result);
    int           gap;
    cell_result_t predicted;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, it.cell_value, it.cell_y, it.cell_x};
    s_tuser  <= it.action;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted = apply_life_item(it);
    pending_cell_results.push_back(fixed ? fixed_result : predicted);
    items_sent++;
    case (it.action)
      lgge_pkg::ACT_WRITE:   writes_sent++;
      lgge_pkg::ACT_READ:    reads_sent++;
      lgge_pkg::ACT_ADVANCE: advances_sent++;
      default: begin
      end
    endcase
  endtask

  // Register writes only go in once the block has handed back every result;
  // each item gives exactly one, so an empty store means the block is idle.
  task automatic write_register(logic reg_index, logic [6:0] value);
    s_tvalid  <= 1'b0;
    burst_left = 0;
    while (pending_cell_results.size() != 0) @(posedge clk);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= reg_index;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (reg_index == lgge_pkg::REG_GRID_WIDTH) begin
      width_reg = value;
    end else begin
      height_reg = value;
    end
  endtask

  task automatic report_mismatch(string what, logic got, logic wanted);
    if (mismatch_count < 40) begin
      $display("MISMATCH at cycle %0d: %s, got %0b, expected %0b",
               cycle_count, what, got, wanted);
    end
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: ready is always high, follows a fixed pattern, or is random,
  // with the mode redrawn whenever the low eight bits of the cycle count are zero.
  // ---------------------------------------------------------------------------
  logic [1:0] stall_mode = 2'd0;

  always @(posedge clk) begin
    if (cycle_count[7:0] == 8'd0) stall_mode <= 2'($urandom_range(0, 3));
    case (stall_mode)
      2'd0:    m_tready <= 1'b1;
      2'd1:    m_tready <= READY_PATTERN[cycle_count[3:0]];
      default: m_tready <= ($urandom_range(0, 2) != 0);
    endcase
  end

  // Each result item is matched against the oldest waiting expectation.
  always @(posedge clk) begin : check_results
    cell_result_t wanted;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (pending_cell_results.size() == 0) begin
        report_mismatch("result item with no item waiting", m_tdata[0], 1'b0);
      end else begin
        wanted = pending_cell_results.pop_front();
        if (m_tdata[0] !== wanted.read_alive) begin
          report_mismatch("read_alive", m_tdata[0], wanted.read_alive);
        end
        if (m_tdata[1] !== wanted.address_error) begin
          report_mismatch("address_error", m_tdata[1], wanted.address_error);
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Run stopped by the cycle limit with %0d results outstanding.",
               pending_cell_results.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence: reset, the directed plan, then random phases over a range
  // of grid sizes, then drain and report.
  // ---------------------------------------------------------------------------
  plan_row_t directed_plan [$];
  int        phase_cols [8] = '{64, 1, 127, 3, 0, 64, 1, 8};
  int        phase_rows [8] = '{64, 1, 100, 3, 9, 1, 64, 8};

  initial begin : main_sequence
    int           cols;
    int           rows;
    int           win_x;
    int           win_y;
    int           win_w;
    int           win_h;
    int           phase_items;
    cell_result_t no_result;

    no_result = '0;
    for (int i = 0; i < 2 * GRID_ROWS; i++) bank_rows[i] = '0;
    cur_bank   = 1'b0;
    width_reg  = lgge_pkg::GRID_REG_RESET;
    height_reg = lgge_pkg::GRID_REG_RESET;

    // After reset the grid is all dead at 64 x 64.
    directed_plan.push_back(fixed_row(lgge_pkg::ACT_READ, 0, 0, 1'b0, 1'b0, 1'b0));
    directed_plan.push_back(fixed_row(lgge_pkg::ACT_READ, 63, 63, 1'b1, 1'b0, 1'b0));
    directed_plan.push_back(fixed_row(lgge_pkg::ACT_WRITE, 63, 63, 1'b1, 1'b0, 1'b0));
    directed_plan.push_back(fixed_row(lgge_pkg::ACT_READ, 63, 63, 1'b0, 1'b1, 1'b0));
    directed_plan.push_back(fixed_row(lgge_pkg::ACT_WRITE, 0, 0, 1'b1, 1'b0, 1'b0));
    // The unused action code has no effect and an all-zero result.
    directed_plan.push_back(fixed_row(ACT_UNUSED, 63, 63, 1'b1, 1'b0, 1'b0));
    directed_plan.push_back(fixed_row(lgge_pkg::ACT_ADVANCE, 0, 0, 1'b0, 1'b0, 1'b0));
    // Lone corner cells die; then a blinker is built and stepped.
    directed_plan.push_back(item_row(lgge_pkg::ACT_READ, 0, 0, 1'b0));
    directed_plan.push_back(item_row(lgge_pkg::ACT_READ, 63, 63, 1'b0));
    directed_plan.push_back(item_row(lgge_pkg::ACT_WRITE, 1, 0, 1'b1));
    directed_plan.push_back(item_row(lgge_pkg::ACT_WRITE, 1, 1, 1'b1));
    directed_plan.push_back(item_row(lgge_pkg::ACT_WRITE, 1, 2, 1'b1));
    directed_plan.push_back(item_row(lgge_pkg::ACT_ADVANCE, 5, 5, 1'b1));
    directed_plan.push_back(item_row(lgge_pkg::ACT_READ, 0, 1, 1'b0));
    directed_plan.push_back(item_row(lgge_pkg::ACT_READ, 1, 0, 1'b0));
    directed_plan.push_back(item_row(lgge_pkg::ACT_WRITE, 1, 1, 1'b0));
    // A small grid: addresses just past either border are flagged.
    directed_plan.push_back(config_row(lgge_pkg::REG_GRID_WIDTH, 5));
    directed_plan.push_back(config_row(lgge_pkg::REG_GRID_HEIGHT, 3));
    directed_plan.push_back(fixed_row(lgge_pkg::ACT_WRITE, 5, 0, 1'b1, 1'b0, 1'b1));
    directed_plan.push_back(fixed_row(lgge_pkg::ACT_READ, 0, 3, 1'b0, 1'b0, 1'b1));
    directed_plan.push_back(item_row(lgge_pkg::ACT_ADVANCE, 0, 0, 1'b0));
    directed_plan.push_back(item_row(lgge_pkg::ACT_READ, 2, 1, 1'b0));
    // Zero width: the grid is empty, every access is flagged.
    directed_plan.push_back(config_row(lgge_pkg::REG_GRID_WIDTH, 0));
    directed_plan.push_back(fixed_row(lgge_pkg::ACT_READ, 0, 0, 1'b0, 1'b0, 1'b1));
    directed_plan.push_back(fixed_row(lgge_pkg::ACT_WRITE, 0, 0, 1'b1, 1'b0, 1'b1));
    directed_plan.push_back(item_row(lgge_pkg::ACT_ADVANCE, 0, 0, 1'b0));
    // Registers at their top value are clipped to the instance size.
    directed_plan.push_back(config_row(lgge_pkg::REG_GRID_WIDTH, 127));
    directed_plan.push_back(config_row(lgge_pkg::REG_GRID_HEIGHT, 127));
    directed_plan.push_back(item_row(lgge_pkg::ACT_READ, 63, 63, 1'b0));
    directed_plan.push_back(item_row(lgge_pkg::ACT_READ, 0, 0, 1'b0));

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_plan[i]) begin
      if (directed_plan[i].kind == ROW_CONFIG) begin
        write_register(directed_plan[i].cfg_reg, directed_plan[i].cfg_value);
      end else begin
        send_item(directed_plan[i].item, directed_plan[i].fixed,
                  directed_plan[i].fixed_result);
      end
    end

    // Random phases: fixed sizes covering the extremes first, then random
    // small and random full-range sizes.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase < 8) begin
        cols = phase_cols[phase];
        rows = phase_rows[phase];
      end else if (phase < 10) begin
        cols = $urandom_range(2, 20);
        rows = $urandom_range(2, 20);
      end else begin
        cols = $urandom_range(1, 127);
        rows = $urandom_range(1, 127);
      end
      write_register(lgge_pkg::REG_GRID_WIDTH, cols[6:0]);
      write_register(lgge_pkg::REG_GRID_HEIGHT, rows[6:0]);
      size_settings++;
      cols  = used_cols();
      rows  = used_rows();
      win_w = (cols < 8) ? cols : 8;
      win_h = (rows < 8) ? rows : 8;
      win_x = (cols == 0) ? 0 : pick_coord(cols - win_w + 1);
      win_y = (rows == 0) ? 0 : pick_coord(rows - win_h + 1);
      // An empty grid only flags addresses, so it gets a short phase.
      phase_items = (cols == 0 || rows == 0) ? 40 : ITEMS_PER_PHASE;
      for (int n = 0; n < phase_items; n++) begin
        send_item(random_item(cols, rows, win_x, win_y, win_w, win_h), 1'b0, no_result);
      end
    end

    s_tvalid <= 1'b0;
    while (pending_cell_results.size() != 0) @(posedge clk);
    // Let any stray result show up before the verdict.
    repeat (2 * GRID_ROWS + 16) @(posedge clk);

    $display("Sent %0d items: %0d writes, %0d reads, %0d advances, %0d unused codes.",
             items_sent, writes_sent, reads_sent, advances_sent,
             items_sent - writes_sent - reads_sent - advances_sent);
    $display("Compared %0d results over %0d random grid sizes plus the directed plan.",
             results_seen, size_settings);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
